// File: hw/rtl/pti_pkg.sv
// ----------------------------------------------------------------------------
// Patricia trie package
// Shared widths, status codes, state encodings and the front-to-back record.
// ----------------------------------------------------------------------------
package pti_pkg;

  localparam int unsigned KeyBits  = 32;
  localparam int unsigned MaxNodes = 256;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned BitW     = $clog2(KeyBits + 2);
  localparam int unsigned LenW     = 6;
  localparam int unsigned StatW    = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  typedef enum logic [StatW-1:0] {
    StInserted = 3'd0,
    StPresent  = 3'd1,
    StFound    = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef enum logic {
    ActInsert = 1'b0,
    ActSearch = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    SIdle,
    SHead,
    SWalkRd,
    SWalkChk,
    SCmp,
    SDiff,
    SWalk2Rd,
    SWalk2Chk,
    SWrite,
    SOut
  } eng_state_e;

  // item as handed from the front to the back
  typedef struct packed {
    logic                 search;
    logic [KeyBits-1:0]   key;
    logic [BitW-1:0]      len;
  } req_t;

  // bit b (1..len) of key k; 0 outside that range
  function automatic logic key_bit(logic [KeyBits-1:0] k, logic [BitW-1:0] b,
                                   logic [BitW-1:0] len);
    logic [BitW-1:0] pos;
    pos = len - b;
    if (b == '0 || b > len) begin
      return 1'b0;
    end
    return k[pos[$clog2(KeyBits)-1:0]];
  endfunction

endpackage

// File: hw/rtl/pti_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/pti_front.sv
// ----------------------------------------------------------------------------
// Patricia trie front end
// Accepts items, fixes the effective key length and queues.
// ----------------------------------------------------------------------------
module pti_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [pti_pkg::KeyBits-1:0] key_i,
  input  logic [pti_pkg::LenW-1:0]    len_cfg_i,
  output logic                        req_valid_o,
  output pti_pkg::req_t               req_o,
  input  logic                        req_take_i
);
  import pti_pkg::*;

  req_t             q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic [BitW-1:0]  len_eff;
  logic             do_push, do_pop;

  always_comb begin
    if (len_cfg_i == '0) begin
      len_eff = BitW'(1);
    end else if (BitW'(len_cfg_i) > BitW'(KeyBits)) begin
      len_eff = BitW'(KeyBits);
    end else begin
      len_eff = BitW'(len_cfg_i);
    end
  end

  assign full        = (cnt_q == (QPtrW+1)'(QDepth));
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != '0);
  assign do_pop      = req_take_i && req_valid_o;
  assign req_o       = q_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_q] <= '{search: action_i, key: key_i, len: len_eff};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> req_valid_o)
    else $error("full queue shows no item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push lost");

endmodule

// File: hw/rtl/pti_engine.sv
// ----------------------------------------------------------------------------
// Patricia trie engine
// Walks the node table for search and insert and splices in new nodes.
// ----------------------------------------------------------------------------
module pti_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  pti_pkg::req_t               req_i,
  output logic                        req_take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [pti_pkg::StatW-1:0]   status_o,
  output logic [pti_pkg::IdxW-1:0]    node_index_o
);
  import pti_pkg::*;

  eng_state_e state_q, state_d;
  req_t       req_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   p_q, p_d, n_q, n_d;
  logic [BitW-1:0]   pbit_q, pbit_d, j_q, j_d;
  logic [StatW-1:0]  stat_q, stat_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              wr_step_q, wr_step_d;

  // node table: key, bit number, left and right links
  logic [IdxW-1:0]   waddr, raddr;
  logic [KeyBits-1:0] kw, kr;
  logic [BitW-1:0]   bw, br;
  logic [IdxW-1:0]   lr, rr;
  logic              we_k, we_b, we_l, we_r;
  logic [IdxW-1:0]   l_addr, r_addr, l_data, r_data;

  pti_ram #(.Width(KeyBits), .Depth(MaxNodes)) u_keys (
    .clk_i, .we_i(we_k), .waddr_i(waddr), .wdata_i(kw), .raddr_i(raddr), .rdata_o(kr));
  pti_ram #(.Width(BitW), .Depth(MaxNodes)) u_bits (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(bw), .raddr_i(raddr), .rdata_o(br));
  pti_ram #(.Width(IdxW), .Depth(MaxNodes)) u_left (
    .clk_i, .we_i(we_l), .waddr_i(l_addr), .wdata_i(l_data), .raddr_i(raddr), .rdata_o(lr));
  pti_ram #(.Width(IdxW), .Depth(MaxNodes)) u_right (
    .clk_i, .we_i(we_r), .waddr_i(r_addr), .wdata_i(r_data), .raddr_i(raddr), .rdata_o(rr));

  logic [IdxW-1:0] new_idx;
  logic            nbit;
  logic            diff_hit;
  logic            kb;

  assign new_idx = count_q[IdxW-1:0];
  assign nbit    = key_bit(req_q.key, br, req_q.len);
  assign kb      = key_bit(req_q.key, j_q, req_q.len);
  assign diff_hit = key_bit(kr, j_q, req_q.len) != key_bit(req_q.key, j_q, req_q.len);

  assign empty        = (state_q != SOut);
  assign status_o     = stat_q;
  assign node_index_o = idx_q;
  assign req_take_o   = (state_q == SIdle) && req_valid_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    p_d       = p_q;
    n_d       = n_q;
    pbit_d    = pbit_q;
    j_d       = j_q;
    stat_d    = stat_q;
    idx_d     = idx_q;
    wr_step_d = wr_step_q;
    raddr     = n_q;
    waddr     = new_idx;
    kw        = req_q.key;
    bw        = j_q;
    we_k      = 1'b0;
    we_b      = 1'b0;
    we_l      = 1'b0;
    we_r      = 1'b0;
    l_addr    = new_idx;
    r_addr    = new_idx;
    l_data    = new_idx;
    r_data    = new_idx;
    case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          raddr = '0;
          state_d = SHead;
        end
      end
      SHead: begin
        idx_d = '0;
        if (count_q == '0) begin
          if (req_q.search) begin
            stat_d  = StNotFound;
            state_d = SOut;
          end else begin
            // head node links to itself
            we_k = 1'b1; we_b = 1'b1; we_l = 1'b1; we_r = 1'b1;
            waddr = '0; bw = '0; l_addr = '0; r_addr = '0;
            l_data = '0; r_data = '0;
            count_d = CntW'(1);
            stat_d  = StInserted;
            state_d = SOut;
          end
        end else begin
          p_d = '0; pbit_d = '0; n_d = lr;
          raddr = lr;
          state_d = SWalkRd;
        end
      end
      SWalkRd: begin
        // data for n now on the read ports
        if (pbit_q < br) begin
          p_d = n_q; pbit_d = br;
          n_d = nbit ? rr : lr;
          raddr = nbit ? rr : lr;
        end else begin
          j_d = BitW'(1);
          state_d = SDiff;
          raddr = n_q;
        end
      end
      SDiff: begin
        raddr = n_q;
        if (j_q > req_q.len) begin
          idx_d = n_q;
          if (req_q.search)      stat_d = StFound;
          else                   stat_d = StPresent;
          state_d = SOut;
        end else if (diff_hit) begin
          idx_d = n_q;
          if (req_q.search) begin
            stat_d = StNotFound; state_d = SOut;
          end else if (count_q == CntW'(MaxNodes)) begin
            idx_d = '0; stat_d = StFull; state_d = SOut;
          end else begin
            p_d = '0; pbit_d = '0;
            state_d = SWalk2Chk;
            raddr = '0;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      SWalk2Chk: begin
        // head data on ports; start second walk at head's left link
        n_d = lr; raddr = lr;
        wr_step_d = 1'b0;
        state_d = SWalk2Rd;
      end
      SWalk2Rd: begin
        if (pbit_q < br && br < j_q) begin
          p_d = n_q; pbit_d = br;
          n_d = nbit ? rr : lr;
          raddr = nbit ? rr : lr;
        end else begin
          raddr = p_q;
          state_d = SWrite;
        end
      end
      SWrite: begin
        // p data on ports: relink the side that pointed at n
        we_k = 1'b1; we_b = 1'b1; we_l = 1'b1; we_r = 1'b1;
        l_data = kb ? n_q : new_idx;
        r_data = kb ? new_idx : n_q;
        if (!wr_step_q) begin
          // first step: write the new node
          wr_step_d = 1'b1;
          raddr = p_q;
        end else begin
          we_k = 1'b0; we_b = 1'b0;
          if (lr == n_q) begin
            we_r = 1'b0; l_addr = p_q; l_data = new_idx;
          end else begin
            we_l = 1'b0; r_addr = p_q; r_data = new_idx;
          end
          count_d = count_q + 1'b1;
          idx_d   = new_idx;
          stat_d  = StInserted;
          state_d = SOut;
        end
      end
      SOut: begin
        if (pop) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) req_q <= req_i;
    p_q       <= p_d;
    n_q       <= n_d;
    pbit_q    <= pbit_d;
    j_q       <= j_d;
    stat_q    <= stat_d;
    idx_q     <= idx_d;
    wr_step_q <= wr_step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxNodes))
    else $error("node count beyond table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SOut && count_q != $past(count_q)) |-> $past(state_q) != SIdle)
    else $error("count moved while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && !pop) |=> state_q == SOut && $stable(stat_q))
    else $error("result dropped");

endmodule

// File: hw/rtl/patricia_trie_insert_search_core.sv
// The engine takes one item at a time; each walk step is one node-table read.
// A two-entry queue ahead of the engine takes items while it works.
// Reset empties the trie and sets key_length to 32; the table is not cleared.
// ----------------------------------------------------------------------------
// Patricia trie insert/search core
// Top level: front queue, walk engine and the key length register.
// ----------------------------------------------------------------------------
module patricia_trie_insert_search_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [pti_pkg::KeyBits-1:0] key_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pti_pkg::StatW-1:0]   status_o,
  output logic [pti_pkg::IdxW-1:0]    node_index_o,
  input  logic                        cfg_we_i,
  input  logic [pti_pkg::LenW-1:0]    cfg_wdata_i
);
  import pti_pkg::*;

  logic [LenW-1:0] key_length_q;
  logic            req_valid, req_take;
  req_t            req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= LenW'(32);
    end else if (cfg_we_i) begin
      key_length_q <= cfg_wdata_i;
    end
  end

  pti_front u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .key_i,
    .len_cfg_i(key_length_q), .req_valid_o(req_valid), .req_o(req),
    .req_take_i(req_take));

  pti_engine u_engine (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_take_o(req_take),
    .empty, .pop, .status_o, .node_index_o);

endmodule

// File: verif/tb_patricia_trie_insert_search_core.sv
// ----------------------------------------------------------------------------
// Patricia trie core testbench
// Drives insert and search items through the queue ports, predicts each
// status and node index with a local trie model, and checks results in order.
// ----------------------------------------------------------------------------
module tb_patricia_trie_insert_search_core;
  import pti_pkg::*;

  localparam int unsigned WdogLimit = 20000;

  typedef struct packed {
    logic        search;
    logic [31:0] key;
  } trie_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] node_index;
  } trie_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        action_i;
  logic [31:0] key_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [7:0]  node_index_o;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;

  patricia_trie_insert_search_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .key_i        (key_i),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .node_index_o (node_index_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // local trie copy
  logic [31:0] trie_key [256];
  int unsigned trie_bit [256];
  int unsigned trie_lft [256];
  int unsigned trie_rgt [256];
  int unsigned trie_cnt;
  logic [5:0]  len_reg;

  trie_item_t   pending_items [$];
  trie_result_t expected_results [$];
  int unsigned  n_errors, n_checked, n_inserts, n_searches;
  int unsigned  send_idle_pct, recv_idle_pct, quiet_cycles;

  function automatic int unsigned eff_len();
    if (len_reg < 1) return 1;
    if (len_reg > 32) return 32;
    return len_reg;
  endfunction

  function automatic int unsigned tbit(logic [31:0] k, int unsigned b, int unsigned l);
    if (b < 1 || b > l) return 0;
    return k[l-b];
  endfunction

  function automatic int unsigned child(int unsigned nd, int unsigned side);
    return side ? trie_rgt[nd] : trie_lft[nd];
  endfunction

  task automatic trie_walk(input logic [31:0] k, input longint unsigned lim,
                           input int unsigned l, output int unsigned p,
                           output int unsigned n);
    p = 0;
    n = trie_lft[0];
    while (trie_bit[p] < trie_bit[n] && trie_bit[n] < lim) begin
      p = n;
      n = child(n, tbit(k, trie_bit[n], l));
    end
  endtask

  task automatic predict_trie(input trie_item_t it);
    int unsigned  l, p, n, j, nw;
    trie_result_t r;
    l = eff_len();
    r = '0;
    if (trie_cnt == 0) begin
      if (!it.search) begin
        trie_key[0] = it.key;
        trie_bit[0] = 0;
        trie_lft[0] = 0;
        trie_rgt[0] = 0;
        trie_cnt = 1;
        r.status = StInserted;
      end else begin
        r.status = StNotFound;
      end
    end else begin
      trie_walk(it.key, 64'hFFFF_FFFF, l, p, n);
      j = l + 1;
      for (int unsigned i = l; i >= 1; i--) begin
        if (tbit(trie_key[n], i, l) != tbit(it.key, i, l)) j = i;
      end
      if (it.search) begin
        r.status = (j == l + 1) ? StFound : StNotFound;
        r.node_index = n[7:0];
      end else if (j == l + 1) begin
        r.status = StPresent;
        r.node_index = n[7:0];
      end else if (trie_cnt >= 256) begin
        r.status = StFull;
      end else begin
        nw = trie_cnt;
        trie_walk(it.key, j, l, p, n);
        if (n == trie_lft[p]) trie_lft[p] = nw;
        else trie_rgt[p] = nw;
        trie_key[nw] = it.key;
        trie_bit[nw] = j;
        if (tbit(it.key, j, l) == 0) begin
          trie_lft[nw] = nw;
          trie_rgt[nw] = n;
        end else begin
          trie_rgt[nw] = nw;
          trie_lft[nw] = n;
        end
        trie_cnt = nw + 1;
        r.status = StInserted;
        r.node_index = nw[7:0];
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      action_i <= 1'b0;
      key_i    <= '0;
    end else begin
      if (push && !full) begin
        predict_trie(trie_item_t'{action_i, key_i});
        if (action_i) n_searches++;
        else n_inserts++;
      end
      if (!(push && full)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          trie_item_t it;
          it = pending_items.pop_front();
          push     <= 1'b1;
          action_i <= it.search;
          key_i    <= it.key;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d", status_o));
        end else begin
          trie_result_t e;
          e = expected_results.pop_front();
          n_checked++;
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
          if (node_index_o !== e.node_index)
            report_mismatch($sformatf("node_index %0d, want %0d", node_index_o,
                                      e.node_index));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (quiet_cycles >= WdogLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic search, input logic [31:0] key);
    pending_items.push_back(trie_item_t'{search, key});
  endtask

  // hold until everything sent has come back, then let the engine settle
  task automatic drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [5:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_reg = v;
  endtask

  // random phase: keys drawn from a small pool so that hits and duplicates occur
  task automatic random_phase(input int unsigned n, input int unsigned l);
    logic [31:0] pool [16];
    logic [31:0] k;
    for (int i = 0; i < 16; i++) pool[i] = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      k = ($urandom_range(99) < 60) ? pool[4'($urandom_range(15))] : $urandom();
      if ($urandom_range(3) == 0) k = k ^ (32'h1 << $urandom_range(31));
      if (l < 32 && $urandom_range(1)) k = k & ((32'h1 << l) - 1);
      queue_item(1'($urandom_range(1)), k);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    push = 1'b0;
    action_i = 1'b0;
    key_i = '0;
    pop = 1'b0;
    len_reg = 6'd32;
    trie_cnt = 0;
    n_errors = 0; n_checked = 0; n_inserts = 0; n_searches = 0;
    send_idle_pct = 14;
    recv_idle_pct = 70;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty trie, extremes, duplicates and beyond-length bits
    queue_item(ActSearch, 32'h0);
    queue_item(ActInsert, 32'hFFFF_FFFF);
    queue_item(ActInsert, 32'hFFFF_FFFF);
    queue_item(ActSearch, 32'hFFFF_FFFF);
    queue_item(ActInsert, 32'h0);
    queue_item(ActInsert, 32'h8000_0000);
    queue_item(ActInsert, 32'h0000_0001);
    queue_item(ActSearch, 32'h0000_0001);
    queue_item(ActSearch, 32'h7FFF_FFFF);
    queue_item(ActInsert, 32'h5555_5555);
    queue_item(ActInsert, 32'hAAAA_AAAA);
    queue_item(ActSearch, 32'hAAAA_AAAA);
    drain();
    write_len(6'd4);
    queue_item(ActSearch, 32'hFFFF_FFF5);
    queue_item(ActInsert, 32'h0000_0003);
    queue_item(ActInsert, 32'h1234_5673);
    drain();
    write_len(6'd0);
    queue_item(ActInsert, 32'h0000_0000);
    queue_item(ActInsert, 32'h0000_0001);
    queue_item(ActSearch, 32'hFFFF_FFFE);
    drain();
    write_len(6'd63);
    random_phase(100, 32);
    drain();
    // fill the table with small keys under length 8, then insert 0x100, equal to key 0 under that length
    send_idle_pct = 70;
    recv_idle_pct = 14;
    write_len(6'd8);
    for (int unsigned i = 0; i < 256; i++) queue_item(ActInsert, i);
    queue_item(ActInsert, 32'h0000_0100);
    drain();
    random_phase(100, 8);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_len(6'd1);
    random_phase(30, 1);
    drain();
    write_len(6'd32);
    random_phase(60, 32);
    drain();

    $display("checked %0d results (%0d inserts, %0d searches), key lengths 0 to 63,",
             n_checked, n_inserts, n_searches);
    $display("including a full table and lowered lengths over deep tries");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
